FILE: hw/rtl/amm_pkg.sv
// ----------------------------------------------------------------------------
// amm_pkg
// Shared types and constants of the adjacency matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package amm_pkg;

  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 35;
  localparam int POS_W  = 3;
  localparam int CNT_W  = 4;
  localparam int OP_W   = 2;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_W  = 3;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [REG_W-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_CYCLES_A     = 3'd1;
  localparam logic [REG_W-1:0] REG_NEG_CYCLES_A = 3'd2;
  localparam logic [REG_W-1:0] REG_CYCLES_B     = 3'd3;
  localparam logic [REG_W-1:0] REG_NEG_CYCLES_B = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  // Control that travels alongside one product term.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             final_entry;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mac_tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/amm_ram.sv
// ----------------------------------------------------------------------------
// amm_ram
// Single-write, single-read matrix store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module amm_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/amm_mac.sv
// ----------------------------------------------------------------------------
// amm_mac
// Shared multiply-accumulate unit: one registered 16x16 product a cycle,
// summed into a 35-bit accumulator that restarts on the first term.
// ----------------------------------------------------------------------------
`default_nettype none

module amm_mac (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic signed [amm_pkg::DATA_W-1:0]  a_i,
  input  wire logic signed [amm_pkg::DATA_W-1:0]  b_i,
  input  wire amm_pkg::mac_tag_t                  tag_i,
  output logic                                    done_o,
  output logic signed      [amm_pkg::SUM_W-1:0]   sum_o,
  output amm_pkg::mac_tag_t                       tag_o
);

  import amm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  mac_tag_t                 tag_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (tag_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_d = (tag_q.first ? '0 : acc_q) + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  assign done_o = tag_q.valid & tag_q.last;
  assign sum_o  = acc_d;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

FILE: hw/rtl/adjacency_matrix_multiply.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_multiply
// Loads two signed 16-bit square matrices entry by entry and, on a compute
// item, emits every entry of their product in row-major order.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  in       | input     | in_valid_i/in_stall_o | operation, in_row, in_col, in_value
//  out      | output    | out_valid_o/out_stall_i | out_row, out_col, product_value,
//           |           |                       | has_cycles, has_negative_cycles, last
//  config   | input     | APB (psel, penable)   | vertex_count and the four flags
//
// A write item is taken whenever the sequencer is idle. A compute item of size n
// keeps the input stalled until its last product entry is done: each entry walks
// n terms through the single multiply-accumulate unit and then drains it.
// A stalled output holds the next entry back until the result register frees.
// Reset clears the sequencer and flags and sets vertex_count to MAX_VERTICES;
// the matrix stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_multiply #(
  parameter int MAX_VERTICES = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [amm_pkg::OP_W-1:0]           operation_i,
  input  wire logic [amm_pkg::POS_W-1:0]          in_row_i,
  input  wire logic [amm_pkg::POS_W-1:0]          in_col_i,
  input  wire logic signed [amm_pkg::DATA_W-1:0]  in_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [amm_pkg::POS_W-1:0]               out_row_o,
  output logic [amm_pkg::POS_W-1:0]               out_col_o,
  output logic signed [amm_pkg::SUM_W-1:0]        product_value_o,
  output logic                                    has_cycles_o,
  output logic                                    has_negative_cycles_o,
  output logic                                    last_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [amm_pkg::APB_AW-1:0]         paddr,
  input  wire logic [amm_pkg::APB_DW-1:0]         pwdata,
  output logic [amm_pkg::APB_DW-1:0]              prdata,
  output logic                                    pready
);

  import amm_pkg::*;

  localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]    MvAddr  = AW'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MvCount = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vertex_count_q;
  logic             cycles_a_q;
  logic             neg_cycles_a_q;
  logic             cycles_b_q;
  logic             neg_cycles_b_q;
  logic [REG_W-1:0] reg_idx;
  logic             cfg_wr;

  state_e           state_q;
  state_e           state_d;
  logic [IW-1:0]    i_q;
  logic [IW-1:0]    i_d;
  logic [IW-1:0]    j_q;
  logic [IW-1:0]    j_d;
  logic [IW-1:0]    k_q;
  logic [IW-1:0]    k_d;
  logic [IW-1:0]    nm1_q;
  logic [IW-1:0]    nm1_d;
  mac_tag_t         tag_q;
  mac_tag_t         tag_d;

  logic             in_acc;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr;
  logic             a_we;
  logic             b_we;
  logic [CNT_W-1:0] n_start;
  logic             start;
  logic             issue_go;
  logic             final_entry;
  logic [AW-1:0]    a_rd_addr;
  logic [AW-1:0]    b_rd_addr;
  logic [DATA_W-1:0] a_rd_data;
  logic [DATA_W-1:0] b_rd_data;

  logic                    mac_done;
  logic signed [SUM_W-1:0] mac_sum;
  mac_tag_t                mac_tag;

  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [POS_W-1:0]        out_row_q;
  logic [POS_W-1:0]        out_col_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_last_q;

  // Configuration registers.
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= MvCount;
      cycles_a_q     <= 1'b0;
      neg_cycles_a_q <= 1'b0;
      cycles_b_q     <= 1'b0;
      neg_cycles_b_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VERTEX_COUNT: vertex_count_q <= pwdata[CNT_W-1:0];
        REG_CYCLES_A:     cycles_a_q     <= pwdata[0];
        REG_NEG_CYCLES_A: neg_cycles_a_q <= pwdata[0];
        REG_CYCLES_B:     cycles_b_q     <= pwdata[0];
        REG_NEG_CYCLES_B: neg_cycles_b_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VERTEX_COUNT: prdata = APB_DW'(vertex_count_q);
      REG_CYCLES_A:     prdata = APB_DW'(cycles_a_q);
      REG_NEG_CYCLES_A: prdata = APB_DW'(neg_cycles_a_q);
      REG_CYCLES_B:     prdata = APB_DW'(cycles_b_q);
      REG_NEG_CYCLES_B: prdata = APB_DW'(neg_cycles_b_q);
      default:          prdata = '0;
    endcase
  end

  // Input decode.
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign wr_ok   = (CNT_W'(in_row_i) < MvCount) && (CNT_W'(in_col_i) < MvCount);
  assign wr_addr = AW'(AW'(in_row_i[IW-1:0]) * MvAddr + AW'(in_col_i[IW-1:0]));
  assign a_we    = in_acc && (operation_i == OP_WRITE_A) && wr_ok;
  assign b_we    = in_acc && (operation_i == OP_WRITE_B) && wr_ok;
  assign n_start = (vertex_count_q > MvCount) ? MvCount : vertex_count_q;
  assign start   = in_acc && (operation_i == OP_COMPUTE) && (n_start != '0);

  assign final_entry = (i_q == nm1_q) && (j_q == nm1_q);
  assign a_rd_addr   = AW'(AW'(i_q) * MvAddr + AW'(k_q));
  assign b_rd_addr   = AW'(AW'(k_q) * MvAddr + AW'(j_q));

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      nm1_q   <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      nm1_q   <= nm1_d;
      tag_q   <= tag_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_go && (k_q == nm1_q)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = final_entry ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    issue_go   = (state_q == ST_ISSUE) && ((k_q != '0) || !out_valid_q || !out_stall_i);
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    nm1_d      = nm1_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          i_d   = '0;
          j_d   = '0;
          k_d   = '0;
          nm1_d = IW'(n_start - CNT_W'(1));
        end
      end
      ST_ISSUE: begin
        if (issue_go) begin
          k_d = (k_q == nm1_q) ? '0 : k_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done && !final_entry) begin
          if (j_q == nm1_q) begin
            j_d = '0;
            i_d = i_q + IW'(1);
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      default: ;
    endcase
    tag_d.valid       = issue_go;
    tag_d.first       = (k_q == '0);
    tag_d.last        = (k_q == nm1_q);
    tag_d.final_entry = final_entry;
    tag_d.row         = POS_W'(i_q);
    tag_d.col         = POS_W'(j_q);
  end

  amm_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_amm_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (a_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_value_i),
    .rd_addr_i (a_rd_addr),
    .rd_data_o (a_rd_data)
  );

  amm_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_amm_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (b_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_value_i),
    .rd_addr_i (b_rd_addr),
    .rd_data_o (b_rd_data)
  );

  amm_mac u_amm_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (a_rd_data),
    .b_i    (b_rd_data),
    .tag_i  (tag_q),
    .done_o (mac_done),
    .sum_o  (mac_sum),
    .tag_o  (mac_tag)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (mac_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      out_row_q  <= mac_tag.row;
      out_col_q  <= mac_tag.col;
      out_sum_q  <= mac_sum;
      out_last_q <= mac_tag.final_entry;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_row_o             = out_row_q;
  assign out_col_o             = out_col_q;
  assign product_value_o       = out_sum_q;
  assign last_o                = out_last_q;
  assign has_cycles_o          = cycles_a_q | cycles_b_q;
  assign has_negative_cycles_o = neg_cycles_a_q | neg_cycles_b_q;

endmodule

`default_nettype wire

FILE: sim/amm_product_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amm_product_checker
// Keeps its own copy of both weight matrices and of the configuration
// registers, updated from every accepted input item and every register write
// on the APB port. A compute item queues the full predicted product. Each
// accepted output item is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module amm_product_checker
  import amm_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [POS_W-1:0]         in_row_i,
  input  logic [POS_W-1:0]         in_col_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [POS_W-1:0]         out_row_i,
  input  logic [POS_W-1:0]         out_col_i,
  input  logic signed [SUM_W-1:0]  product_value_i,
  input  logic                     has_cycles_i,
  input  logic                     has_negative_cycles_i,
  input  logic                     last_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [APB_AW-1:0]        paddr_i,
  input  logic [APB_DW-1:0]        pwdata_i,
  output int                       failures_o,
  output int                       entries_due_o
);

  typedef struct packed {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    cyc;
    logic                    neg;
    logic                    last;
  } product_entry_t;

  logic signed [DATA_W-1:0] weight_a [MAX_N][MAX_N];
  logic signed [DATA_W-1:0] weight_b [MAX_N][MAX_N];
  logic [CNT_W-1:0] size_reg = CNT_W'(MAX_N);
  logic cyc_a = 1'b0;
  logic neg_a = 1'b0;
  logic cyc_b = 1'b0;
  logic neg_b = 1'b0;
  product_entry_t product_q[$];
  int mismatch_count = 0;
  int due_count = 0;

  assign failures_o    = mismatch_count;
  assign entries_due_o = due_count;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    product_entry_t want;
    int n;
    longint sum;
    if (!rst_ni) begin
      size_reg = CNT_W'(MAX_N);
      cyc_a = 1'b0;
      neg_a = 1'b0;
      cyc_b = 1'b0;
      neg_b = 1'b0;
      product_q.delete();
      due_count <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (product_q.size() == 0) begin
          report($sformatf("unexpected product entry at row %0d col %0d, value %0d",
                           out_row_i, out_col_i, product_value_i));
        end else begin
          want = product_q.pop_front();
          if (out_row_i !== want.row)
            report($sformatf("out_row %0d, expected %0d", out_row_i, want.row));
          if (out_col_i !== want.col)
            report($sformatf("out_col %0d, expected %0d", out_col_i, want.col));
          if (product_value_i !== want.value)
            report($sformatf("row %0d col %0d: product_value %0d, expected %0d",
                             want.row, want.col, product_value_i, want.value));
          if (has_cycles_i !== want.cyc)
            report($sformatf("has_cycles %b, expected %b", has_cycles_i, want.cyc));
          if (has_negative_cycles_i !== want.neg)
            report($sformatf("has_negative_cycles %b, expected %b",
                             has_negative_cycles_i, want.neg));
          if (last_i !== want.last)
            report($sformatf("row %0d col %0d: last %b, expected %b",
                             want.row, want.col, last_i, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (operation_i)
          OP_WRITE_A: weight_a[in_row_i][in_col_i] = in_value_i;
          OP_WRITE_B: weight_b[in_row_i][in_col_i] = in_value_i;
          OP_COMPUTE: begin
            n = (size_reg > MAX_N) ? MAX_N : int'(size_reg);
            for (int i = 0; i < n; i++) begin
              for (int j = 0; j < n; j++) begin
                sum = 0;
                for (int k = 0; k < n; k++)
                  sum += longint'(weight_a[i][k]) * longint'(weight_b[k][j]);
                want.row   = i[POS_W-1:0];
                want.col   = j[POS_W-1:0];
                want.value = sum[SUM_W-1:0];
                want.cyc   = cyc_a | cyc_b;
                want.neg   = neg_a | neg_b;
                want.last  = (i == n - 1) && (j == n - 1);
                product_q.push_back(want);
              end
            end
          end
          default: ;
        endcase
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_AW-1:2])
          REG_VERTEX_COUNT: size_reg = pwdata_i[CNT_W-1:0];
          REG_CYCLES_A:     cyc_a = pwdata_i[0];
          REG_NEG_CYCLES_A: neg_a = pwdata_i[0];
          REG_CYCLES_B:     cyc_b = pwdata_i[0];
          REG_NEG_CYCLES_B: neg_b = pwdata_i[0];
          default: ;
        endcase
      end
      due_count <= product_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for adjacency_matrix_multiply. Loads both matrices, changes the
// size and flag registers between phases and requests products, with random
// gaps on the input and random stalls on the output. A separate checker
// predicts every product entry; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import amm_pkg::*;

  localparam int MAX_N = 8;
  localparam int ITEM_TARGET = 460;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [REG_W-1:0] REG_UNUSED_LO = 3'd5;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SQUARE} stall_style_e;
  typedef enum {VAL_FULL, VAL_EXTREME, VAL_SMALL} value_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [OP_W-1:0] operation_i = OP_WRITE_A;
  logic [POS_W-1:0] in_row_i = '0;
  logic [POS_W-1:0] in_col_i = '0;
  logic signed [DATA_W-1:0] in_value_i = '0;
  logic out_stall_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  logic in_stall_o;
  logic out_valid_o;
  logic [POS_W-1:0] out_row_o;
  logic [POS_W-1:0] out_col_o;
  logic signed [SUM_W-1:0] product_value_o;
  logic has_cycles_o;
  logic has_negative_cycles_o;
  logic last_o;
  logic [APB_DW-1:0] prdata;
  logic pready;

  int failures;
  int entries_due;

  stall_style_e stall_style = STALL_NONE;
  int stall_run = 0;
  int stall_period = 1;

  value_style_e value_style = VAL_FULL;
  int burst_left = 0;
  int items_sent = 0;
  int size_now = MAX_N;
  bit loaded_a [MAX_N*MAX_N];
  bit loaded_b [MAX_N*MAX_N];

  adjacency_matrix_multiply dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .in_row_i              (in_row_i),
    .in_col_i              (in_col_i),
    .in_value_i            (in_value_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_row_o             (out_row_o),
    .out_col_o             (out_col_o),
    .product_value_o       (product_value_o),
    .has_cycles_o          (has_cycles_o),
    .has_negative_cycles_o (has_negative_cycles_o),
    .last_o                (last_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  amm_product_checker #(.MAX_N(MAX_N)) u_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .operation_i           (operation_i),
    .in_row_i              (in_row_i),
    .in_col_i              (in_col_i),
    .in_value_i            (in_value_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_row_i             (out_row_o),
    .out_col_i             (out_col_o),
    .product_value_i       (product_value_o),
    .has_cycles_i          (has_cycles_o),
    .has_negative_cycles_i (has_negative_cycles_o),
    .last_i                (last_o),
    .psel_i                (psel),
    .penable_i             (penable),
    .pwrite_i              (pwrite),
    .pready_i              (pready),
    .paddr_i               (paddr),
    .pwdata_i              (pwdata),
    .failures_o            (failures),
    .entries_due_o         (entries_due)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_style  <= stall_style_e'($urandom_range(0, 3));
      stall_run    <= $urandom_range(16, 160);
      stall_period <= $urandom_range(1, 6);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_run / stall_period) % 2 == 1);
    endcase
  end

  function automatic int pick_value();
    case (value_style)
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      VAL_SMALL: return int'($urandom_range(0, 16)) - 8;
      default:   return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input int row, input int col,
                           input int value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    in_row_i    <= row[POS_W-1:0];
    in_col_i    <= col[POS_W-1:0];
    in_value_i  <= value[DATA_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (op == OP_WRITE_A) loaded_a[row*MAX_N + col] = 1'b1;
    if (op == OP_WRITE_B) loaded_b[row*MAX_N + col] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Every entry that the current size reads gets written before a product.
  task automatic request_product();
    for (int i = 0; i < size_now; i++) begin
      for (int k = 0; k < size_now; k++) begin
        if (!loaded_a[i*MAX_N + k]) send_item(OP_WRITE_A, i, k, pick_value());
        if (!loaded_b[i*MAX_N + k]) send_item(OP_WRITE_B, i, k, pick_value());
      end
    end
    send_item(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (entries_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [REG_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int vc, input bit ca, input bit na, input bit cb,
                           input bit nb);
    logic [APB_DW-1:0] noise;
    noise = $urandom();
    apb_write(REG_VERTEX_COUNT, {noise[APB_DW-1:CNT_W], vc[CNT_W-1:0]});
    noise = $urandom();
    apb_write(REG_CYCLES_A, {noise[APB_DW-1:1], ca});
    noise = $urandom();
    apb_write(REG_NEG_CYCLES_A, {noise[APB_DW-1:1], na});
    noise = $urandom();
    apb_write(REG_CYCLES_B, {noise[APB_DW-1:1], cb});
    noise = $urandom();
    apb_write(REG_NEG_CYCLES_B, {noise[APB_DW-1:1], nb});
    if ($urandom_range(0, 3) == 0)
      apb_write(REG_UNUSED_LO + REG_W'($urandom_range(0, 2)), $urandom());
    size_now = (vc > MAX_N) ? MAX_N : vc;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 10) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, MAX_N - 1);
    if (r < 17) return MAX_N;
    return $urandom_range(MAX_N + 1, (1 << CNT_W) - 1);
  endfunction

  initial begin
    #50_000_000;
    $display("adjacency_matrix_multiply regression: fail");
    $finish;
  end

  initial begin
    int phase;
    int steps;
    int pick;
    logic [OP_W-1:0] wr_op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(2, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(OP_WRITE_A, 0, 0, -32768);
    send_item(OP_WRITE_A, 0, 1, -32768);
    send_item(OP_WRITE_A, 1, 0, 32767);
    send_item(OP_WRITE_A, 1, 1, -1);
    send_item(OP_WRITE_B, 0, 0, -32768);
    send_item(OP_WRITE_B, 1, 0, -32768);
    send_item(OP_WRITE_B, 0, 1, 32767);
    send_item(OP_WRITE_B, 1, 1, 1);
    send_item(OP_WRITE_A, 7, 7, 32767);
    send_item(OP_WRITE_B, 7, 7, -32768);
    send_item(OP_UNUSED, 7, 7, -1);
    send_item(OP_COMPUTE, 7, 0, 0);
    wait_until_drained();
    configure(0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_item(OP_COMPUTE, 0, 7, -1);
    wait_until_drained();
    configure(1, 1'b0, 1'b1, 1'b1, 1'b0);
    request_product();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_until_drained();
      value_style = value_style_e'($urandom_range(0, 2));
      configure((phase == 0) ? (1 << CNT_W) - 1 : (phase == 1) ? MAX_N : pick_size(),
                $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1));
      if (phase == 0) begin
        // Full-width extremes: one entry at the largest sum, one at the smallest.
        for (int k = 0; k < MAX_N; k++) begin
          send_item(OP_WRITE_A, 0, k, -32768);
          send_item(OP_WRITE_B, k, 0, -32768);
          send_item(OP_WRITE_A, 1, k, 32767);
        end
      end else begin
        steps = $urandom_range(4, 24);
        for (int s = 0; s < steps; s++) begin
          pick  = $urandom_range(0, 99);
          wr_op = $urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A;
          if (pick < 12) begin
            request_product();
          end else if (pick < 17) begin
            send_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
          end else if (pick < 20) begin
            wait_until_drained();
          end else if (pick < 85 && size_now > 0) begin
            send_item(wr_op, $urandom_range(0, size_now - 1), $urandom_range(0, size_now - 1),
                      pick_value());
          end else begin
            send_item(wr_op, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
          end
        end
      end
      request_product();
      phase++;
    end

    wait_until_drained();
    repeat (64) @(posedge clk_i);
    if (failures == 0) begin
      $display("adjacency_matrix_multiply regression: pass");
    end else begin
      $display("adjacency_matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule
